// ----- design/twd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the vertex twist deformer.
// No dependencies; imported by every module of the block.
package twd_pkg;

    // Twist rate register width, signed Q4.12
    localparam int RATE_W = 16;

    // Angle constants, 27 fraction bits
    localparam longint ANG_TWO_PI  = 843314857;
    localparam longint ANG_PI      = 421657428;
    localparam longint ANG_HALF_PI = 210828714;

    // CORDIC start value and unit, 30 fraction bits
    localparam longint CORDIC_GAIN_Q30 = 652032874;
    localparam longint ONE_Q30         = 1073741824;
    localparam longint ROUND_Q30       = 536870912;

    // Reduced angle is below 2*pi, so it fits in 30 bits
    localparam int RED_W = 30;
    // Residual angle, CORDIC x/y, and clamped sine/cosine widths
    localparam int ZW  = 31;
    localparam int CW  = 33;
    localparam int SCW = 32;

    typedef logic signed [ZW-1:0]  twd_ang_t;
    typedef logic signed [CW-1:0]  twd_cord_t;
    typedef logic signed [SCW-1:0] twd_trig_t;

    // Per-stage control carried down the cell chain
    typedef struct packed {
        logic valid;
        logic neg;
    } twd_ctl_t;

    // atan(2^-i) in Q27, rounded to nearest
    function automatic twd_ang_t atan_q27(input logic [4:0] idx);
        twd_ang_t val;
        case (idx)
            5'd0:    val = ZW'(105414357);
            5'd1:    val = ZW'(62229729);
            5'd2:    val = ZW'(32880480);
            5'd3:    val = ZW'(16690645);
            5'd4:    val = ZW'(8377711);
            5'd5:    val = ZW'(4192939);
            5'd6:    val = ZW'(2096981);
            5'd7:    val = ZW'(1048555);
            5'd8:    val = ZW'(524285);
            5'd9:    val = ZW'(262144);
            5'd10:   val = ZW'(131072);
            5'd11:   val = ZW'(65536);
            5'd12:   val = ZW'(32768);
            5'd13:   val = ZW'(16384);
            5'd14:   val = ZW'(8192);
            5'd15:   val = ZW'(4096);
            5'd16:   val = ZW'(2048);
            5'd17:   val = ZW'(1024);
            5'd18:   val = ZW'(512);
            5'd19:   val = ZW'(256);
            5'd20:   val = ZW'(128);
            5'd21:   val = ZW'(64);
            5'd22:   val = ZW'(32);
            5'd23:   val = ZW'(16);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/vertex_twist_deformer.sv -----
`timescale 1ns / 1ps
// Top level of the vertex twist deformer: input skid, angle product, reduction
// chain, fold, CORDIC chain, clamp and rotation. Depends on twd_pkg and all twd_ cells.
//
//  channel  | direction | transfer carries
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | one vertex: pos x/y/z, norm x/y/z
//  m_axis   | out       | one twisted vertex, same layout
//  cfg      | in        | twist_rate, signed Q4.12
//
// One vertex per cycle sustained while m_axis_tready stays high. The chain is the product,
// POS_WIDTH-12 reduction cells, fold, CORDIC_STAGES cells, clamp and two rotation
// stages. Reset clears only control; no clearing pass.
// A result waiting at m_axis with m_axis_tready low freezes the whole chain; a
// one-entry skid at the input keeps s_axis_tready registered and takes one more
// vertex during a stall.
module vertex_twist_deformer
    import twd_pkg::*;
#(
    parameter int POS_WIDTH     = 24,
    parameter int NORM_WIDTH    = 16,
    parameter int CORDIC_STAGES = 16,
    localparam int PAY_W  = 3 * POS_WIDTH + 3 * NORM_WIDTH,
    localparam int DATA_W = ((PAY_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RATE_W-1:0] cfg_data,       // twist_rate
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // in_pos_x, in_pos_y, in_pos_z, in_norm_x, in_norm_y, in_norm_z, zero pad
    input  logic [DATA_W-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z, zero pad
    output logic [DATA_W-1:0] m_axis_tdata
);

    localparam int AW   = POS_WIDTH + RATE_W;
    localparam int K    = AW - 30;
    localparam int NMOD = AW - 28;
    localparam int RW   = AW + 2;
    localparam logic [RW-1:0] OFFSET = RW'(ANG_TWO_PI) << K;
    localparam int PX0 = 0;
    localparam int PY0 = POS_WIDTH;
    localparam int PZ0 = 2 * POS_WIDTH;
    localparam int NX0 = 3 * POS_WIDTH;
    localparam int NY0 = 3 * POS_WIDTH + NORM_WIDTH;
    localparam int NZ0 = 3 * POS_WIDTH + 2 * NORM_WIDTH;

    logic              adv;
    logic [RATE_W-1:0] rate_reg;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [PAY_W-1:0]  skid_data_reg;
    logic              pipe_in_valid;
    logic [PAY_W-1:0]  pipe_in_pay;
    logic signed [POS_WIDTH-1:0] pipe_in_py;

    twd_ctl_t          ang_ctl_reg;
    logic signed [AW-1:0] ang_reg;
    logic [PAY_W-1:0]  ang_pay_reg;

    logic [RW-1:0]     mod_r   [0:NMOD];
    twd_ctl_t          mod_ctl [0:NMOD];
    logic [PAY_W-1:0]  mod_pay [0:NMOD];

    logic [RED_W-1:0]  red_val;
    twd_ang_t          z_wrap;
    twd_ang_t          z_next;
    logic              neg_next;
    twd_ctl_t          fold_ctl_reg;
    twd_ang_t          fold_z_reg;
    logic [PAY_W-1:0]  fold_pay_reg;

    twd_cord_t         cx   [0:CORDIC_STAGES];
    twd_cord_t         cy   [0:CORDIC_STAGES];
    twd_ang_t          cz   [0:CORDIC_STAGES];
    twd_ctl_t          cctl [0:CORDIC_STAGES];
    logic [PAY_W-1:0]  cpay [0:CORDIC_STAGES];

    twd_cord_t         x_cl;
    twd_cord_t         y_cl;
    twd_trig_t         cs_next;
    twd_trig_t         sn_next;
    twd_ctl_t          clamp_ctl_reg;
    twd_trig_t         cs_reg;
    twd_trig_t         sn_reg;
    logic [PAY_W-1:0]  clamp_pay_reg;

    logic              mul_valid_reg;
    logic              out_valid_reg;
    logic [POS_WIDTH-1:0]  o_px;
    logic [POS_WIDTH-1:0]  o_py;
    logic [POS_WIDTH-1:0]  o_pz;
    logic [NORM_WIDTH-1:0] o_nx;
    logic [NORM_WIDTH-1:0] o_ny;
    logic [NORM_WIDTH-1:0] o_nz;

    // whole chain moves unless a result is held at the output
    assign adv = !out_valid_reg || m_axis_tready;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= '0;
        else if (cfg_valid)
            rate_reg <= cfg_data;
    end

    // input skid: holds one vertex while the chain is stalled
    assign s_axis_tready = !skid_valid_reg;
    assign pipe_in_valid = skid_valid_reg || s_axis_tvalid;
    assign pipe_in_pay   = skid_valid_reg ? skid_data_reg : s_axis_tdata[PAY_W-1:0];
    assign pipe_in_py    = pipe_in_pay[PY0 +: POS_WIDTH];

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (adv)
            skid_valid_next = 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!adv && s_axis_tvalid && s_axis_tready)
            skid_data_reg <= s_axis_tdata[PAY_W-1:0];
    end

    // twist angle = y * rate, Q27
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_ctl_reg <= '0;
        else if (adv)
            ang_ctl_reg <= '{valid: pipe_in_valid, neg: 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg     <= pipe_in_py * $signed(rate_reg);
            ang_pay_reg <= pipe_in_pay;
        end
    end

    // offset by a multiple of 2*pi so the reduction works on a nonnegative value
    assign mod_r[0]   = {{2{ang_reg[AW-1]}}, ang_reg} + OFFSET;
    assign mod_ctl[0] = ang_ctl_reg;
    assign mod_pay[0] = ang_pay_reg;

    // reduction chain, largest multiple first
    for (genvar g = 0; g < NMOD; g++)
    begin : g_mod
        twd_mod_cell #(
            .RW    (RW),
            .SHIFT (NMOD - 1 - g),
            .PAY_W (PAY_W)
        ) u_mod (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (mod_ctl[g]),
            .r_in    (mod_r[g]),
            .pay_in  (mod_pay[g]),
            .ctl_out (mod_ctl[g+1]),
            .r_out   (mod_r[g+1]),
            .pay_out (mod_pay[g+1])
        );
    end

    // map to (-pi, pi], then fold into [-pi/2, pi/2] with a sign flip
    assign red_val = mod_r[NMOD][RED_W-1:0];

    always_comb
    begin
        z_wrap = $signed({1'b0, red_val});
        if (z_wrap > ZW'(ANG_PI))
            z_wrap = z_wrap - ZW'(ANG_TWO_PI);
        neg_next = 1'b0;
        z_next   = z_wrap;
        if (z_wrap > ZW'(ANG_HALF_PI))
        begin
            z_next   = z_wrap - ZW'(ANG_PI);
            neg_next = 1'b1;
        end
        else if (z_wrap < -ZW'(ANG_HALF_PI))
        begin
            z_next   = z_wrap + ZW'(ANG_PI);
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_ctl_reg <= '0;
        else if (adv)
            fold_ctl_reg <= '{valid: mod_ctl[NMOD].valid, neg: neg_next};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_z_reg   <= z_next;
            fold_pay_reg <= mod_pay[NMOD];
        end
    end

    // CORDIC chain
    assign cx[0]   = CW'(CORDIC_GAIN_Q30);
    assign cy[0]   = '0;
    assign cz[0]   = fold_z_reg;
    assign cctl[0] = fold_ctl_reg;
    assign cpay[0] = fold_pay_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        twd_cordic_cell #(
            .IDX   (i),
            .PAY_W (PAY_W)
        ) u_cordic (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (cctl[i]),
            .x_in    (cx[i]),
            .y_in    (cy[i]),
            .z_in    (cz[i]),
            .pay_in  (cpay[i]),
            .ctl_out (cctl[i+1]),
            .x_out   (cx[i+1]),
            .y_out   (cy[i+1]),
            .z_out   (cz[i+1]),
            .pay_out (cpay[i+1])
        );
    end

    // clamp to [-1, 1] and undo the fold
    always_comb
    begin
        x_cl = cx[CORDIC_STAGES];
        if (x_cl > CW'(ONE_Q30))
            x_cl = CW'(ONE_Q30);
        else if (x_cl < -CW'(ONE_Q30))
            x_cl = -CW'(ONE_Q30);
        y_cl = cy[CORDIC_STAGES];
        if (y_cl > CW'(ONE_Q30))
            y_cl = CW'(ONE_Q30);
        else if (y_cl < -CW'(ONE_Q30))
            y_cl = -CW'(ONE_Q30);
        if (cctl[CORDIC_STAGES].neg)
        begin
            x_cl = -x_cl;
            y_cl = -y_cl;
        end
        cs_next = x_cl[SCW-1:0];
        sn_next = y_cl[SCW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clamp_ctl_reg <= '0;
        else if (adv)
            clamp_ctl_reg <= cctl[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs_reg        <= cs_next;
            sn_reg        <= sn_next;
            clamp_pay_reg <= cpay[CORDIC_STAGES];
        end
    end

    // rotation of position and normal
    twd_rot_cell #(
        .W (POS_WIDTH)
    ) u_rot_pos (
        .clk      (clk),
        .en       (adv),
        .a_in     ($signed(clamp_pay_reg[PX0 +: POS_WIDTH])),
        .b_in     ($signed(clamp_pay_reg[PZ0 +: POS_WIDTH])),
        .pass_in  (clamp_pay_reg[PY0 +: POS_WIDTH]),
        .cs       (cs_reg),
        .sn       (sn_reg),
        .a_out    (o_px),
        .b_out    (o_pz),
        .pass_out (o_py)
    );

    twd_rot_cell #(
        .W (NORM_WIDTH)
    ) u_rot_norm (
        .clk      (clk),
        .en       (adv),
        .a_in     ($signed(clamp_pay_reg[NX0 +: NORM_WIDTH])),
        .b_in     ($signed(clamp_pay_reg[NZ0 +: NORM_WIDTH])),
        .pass_in  (clamp_pay_reg[NY0 +: NORM_WIDTH]),
        .cs       (cs_reg),
        .sn       (sn_reg),
        .a_out    (o_nx),
        .b_out    (o_nz),
        .pass_out (o_ny)
    );

    // valid tracking through the two rotation stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_valid_reg <= clamp_ctl_reg.valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'({o_nz, o_ny, o_nx, o_pz, o_py, o_px});

    // checks
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !adv) |=> skid_valid_reg)
        else $error("skid entry lost during stall");

    a_skid_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !adv) |=> skid_valid_reg)
        else $error("stalled transfer not captured in skid");

    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_ctl[NMOD].valid |-> (mod_r[NMOD] < RW'(ANG_TWO_PI)))
        else $error("reduced angle not below 2*pi");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        fold_ctl_reg.valid |->
            (fold_z_reg <= ZW'(ANG_HALF_PI) && fold_z_reg >= -ZW'(ANG_HALF_PI)))
        else $error("folded angle outside half-pi range");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        clamp_ctl_reg.valid |->
            (cs_reg <= SCW'(ONE_Q30) && cs_reg >= -SCW'(ONE_Q30) &&
             sn_reg <= SCW'(ONE_Q30) && sn_reg >= -SCW'(ONE_Q30)))
        else $error("sine or cosine outside unit range");

endmodule

// ----- design/twd_mod_cell.sv -----
`timescale 1ns / 1ps
// One step of the angle reduction chain: conditional subtract of 2*pi << SHIFT.
// Depends on twd_pkg.
module twd_mod_cell
    import twd_pkg::*;
#(
    parameter int RW    = 42,
    parameter int SHIFT = 0,
    parameter int PAY_W = 120
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  twd_ctl_t         ctl_in,
    input  logic [RW-1:0]    r_in,
    input  logic [PAY_W-1:0] pay_in,
    output twd_ctl_t         ctl_out,
    output logic [RW-1:0]    r_out,
    output logic [PAY_W-1:0] pay_out
);

    localparam logic [RW-1:0] STEP = RW'(ANG_TWO_PI) << SHIFT;

    twd_ctl_t         ctl_reg;
    logic [RW-1:0]    r_reg;
    logic [RW-1:0]    r_next;
    logic [PAY_W-1:0] pay_reg;

    // restoring subtract
    always_comb
    begin
        r_next = (r_in >= STEP) ? (r_in - STEP) : r_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            pay_reg <= pay_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign r_out   = r_reg;
    assign pay_out = pay_reg;

endmodule

// ----- design/twd_cordic_cell.sv -----
`timescale 1ns / 1ps
// One CORDIC rotation-mode micro-rotation, registered.
// Depends on twd_pkg (atan table, widths).
module twd_cordic_cell
    import twd_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int PAY_W = 120
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  twd_ctl_t         ctl_in,
    input  twd_cord_t        x_in,
    input  twd_cord_t        y_in,
    input  twd_ang_t         z_in,
    input  logic [PAY_W-1:0] pay_in,
    output twd_ctl_t         ctl_out,
    output twd_cord_t        x_out,
    output twd_cord_t        y_out,
    output twd_ang_t         z_out,
    output logic [PAY_W-1:0] pay_out
);

    localparam twd_ang_t ATAN_I = atan_q27(5'(IDX));

    twd_ctl_t         ctl_reg;
    twd_cord_t        x_reg;
    twd_cord_t        x_next;
    twd_cord_t        y_reg;
    twd_cord_t        y_next;
    twd_ang_t         z_reg;
    twd_ang_t         z_next;
    logic [PAY_W-1:0] pay_reg;
    twd_cord_t        dx;
    twd_cord_t        dy;

    // rotate toward zero residual angle
    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN_I;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN_I;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            pay_reg <= pay_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign pay_out = pay_reg;

endmodule

// ----- design/twd_rot_cell.sv -----
`timescale 1ns / 1ps
// Rotates one (x, z) pair by (cos, sin): product stage, then round and saturate.
// Depends on twd_pkg (trig width, rounding constant).
module twd_rot_cell
    import twd_pkg::*;
#(
    parameter int W = 24
)
(
    input  logic                clk,
    input  logic                en,
    input  logic signed [W-1:0] a_in,
    input  logic signed [W-1:0] b_in,
    input  logic        [W-1:0] pass_in,
    input  twd_trig_t           cs,
    input  twd_trig_t           sn,
    output logic        [W-1:0] a_out,
    output logic        [W-1:0] b_out,
    output logic        [W-1:0] pass_out
);

    localparam int PRW = W + SCW;
    localparam int SW  = PRW + 1;
    localparam int TW  = SW - 30;
    localparam logic signed [TW-1:0] HI = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [TW-1:0] LO = {4'b1111, {(W-1){1'b0}}};

    logic signed [PRW-1:0] p_ac_reg;
    logic signed [PRW-1:0] p_bs_reg;
    logic signed [PRW-1:0] p_as_reg;
    logic signed [PRW-1:0] p_bc_reg;
    logic        [W-1:0]   pass1_reg;
    logic signed [SW-1:0]  sum_a;
    logic signed [SW-1:0]  sum_b;
    logic signed [TW-1:0]  sh_a;
    logic signed [TW-1:0]  sh_b;
    logic        [W-1:0]   a_next;
    logic        [W-1:0]   b_next;
    logic        [W-1:0]   a_reg;
    logic        [W-1:0]   b_reg;
    logic        [W-1:0]   pass2_reg;

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_ac_reg  <= a_in * cs;
            p_bs_reg  <= b_in * sn;
            p_as_reg  <= a_in * sn;
            p_bc_reg  <= b_in * cs;
            pass1_reg <= pass_in;
        end
    end

    // sums, round half up, saturate
    always_comb
    begin
        sum_a = SW'(p_ac_reg) - SW'(p_bs_reg) + SW'(ROUND_Q30);
        sum_b = SW'(p_as_reg) + SW'(p_bc_reg) + SW'(ROUND_Q30);
        sh_a  = TW'(sum_a >>> 30);
        sh_b  = TW'(sum_b >>> 30);
        if (sh_a > HI)
            a_next = HI[W-1:0];
        else if (sh_a < LO)
            a_next = LO[W-1:0];
        else
            a_next = sh_a[W-1:0];
        if (sh_b > HI)
            b_next = HI[W-1:0];
        else if (sh_b < LO)
            b_next = LO[W-1:0];
        else
            b_next = sh_b[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            pass2_reg <= pass1_reg;
        end
    end

    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign pass_out = pass2_reg;

endmodule

// ----- tb/vertex_twist_deformer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vertex_twist_deformer: stream driver, output monitor and
// a bit-exact twist predictor (angle reduction, CORDIC sine/cosine, saturating rotation).
// Depends on twd_pkg and the design files under design/.
module vertex_twist_deformer_tb
    import twd_pkg::*;
;

    localparam int POS_W       = 24;
    localparam int NORM_W      = 16;
    localparam int STAGES      = 16;
    localparam int DATA_W      = ((3 * POS_W + 3 * NORM_W + 7) / 8) * 8;
    localparam int LATENCY     = POS_W + STAGES - 7;
    localparam int PHASES      = 8;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int CHOKE_CYCLES     = 400;

    // atan(2^-i), 27 fraction bits, rounded to nearest
    localparam longint ATAN_Q27 [24] = '{
        105414357, 62229729, 32880480, 16690645,
        8377711, 4192939, 2096981, 1048555,
        524285, 262144, 131072, 65536,
        32768, 16384, 8192, 4096,
        2048, 1024, 512, 256,
        128, 64, 32, 16
    };

    // one vertex as packed on tdata, pos_x in the lowest bits
    typedef struct packed {
        logic signed [NORM_W-1:0] norm_z;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_x;
    } vertex_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_valid     = 1'b0;
    logic              cfg_ready;
    logic [RATE_W-1:0] cfg_data      = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // in_pos_x, in_pos_y, in_pos_z, in_norm_x, in_norm_y, in_norm_z
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
    logic [DATA_W-1:0] m_axis_tdata;

    // predictor state and scoreboard
    logic signed [RATE_W-1:0] model_rate = '0;
    vertex_t vertices_waiting[$];
    vertex_t twisted_due[$];
    vertex_t due_vtx;
    vertex_t seen_vtx;
    int      mismatches      = 0;
    int      vertices_sent   = 0;
    int      results_checked = 0;
    int      rate_writes     = 0;

    // handshake pacing
    int      src_gap        = 0;
    bit      src_burst      = 1'b0;
    int      sink_wait      = 0;
    bit      sink_burst     = 1'b0;
    int      choke_requests = 0;
    int      choke_served   = 0;

    always #5 clk = ~clk;

    vertex_twist_deformer #(
        .POS_WIDTH     (POS_W),
        .NORM_WIDTH    (NORM_W),
        .CORDIC_STAGES (STAGES)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // sine and cosine of a Q27 angle, 30 fraction bits
    function automatic void twist_sin_cos(input longint ang, output longint sn,
                                          output longint cs);
        longint r;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        int     i;
        r = ang % ANG_TWO_PI;
        if (r < 0)
            r += ANG_TWO_PI;
        if (r > ANG_PI)
            r -= ANG_TWO_PI;
        // fold into [-pi/2, pi/2], flipping both results
        flip = 1'b0;
        if (r > ANG_HALF_PI)
        begin
            r -= ANG_PI;
            flip = 1'b1;
        end
        else if (r < -ANG_HALF_PI)
        begin
            r += ANG_PI;
            flip = 1'b1;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0)
            begin
                x -= dx;
                y += dy;
                r -= ATAN_Q27[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                r += ATAN_Q27[i];
            end
        end
        if (x > ONE_Q30)
            x = ONE_Q30;
        if (x < -ONE_Q30)
            x = -ONE_Q30;
        if (y > ONE_Q30)
            y = ONE_Q30;
        if (y < -ONE_Q30)
            y = -ONE_Q30;
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    // a*ca + b*cb, rounded half up from Q30, saturated to w bits
    function automatic longint rotate_sat(longint a, longint ca, longint b, longint cb,
                                          int w);
        longint acc;
        longint top;
        acc = (a * ca + b * cb + ROUND_Q30) >>> 30;
        top = (longint'(1) << (w - 1)) - 1;
        if (acc > top)
            return top;
        if (acc < -top - 1)
            return -top - 1;
        return acc;
    endfunction

    function automatic vertex_t twist_vertex(vertex_t v, logic signed [RATE_W-1:0] rate);
        vertex_t t;
        longint  sn;
        longint  cs;
        twist_sin_cos(longint'(v.pos_y) * longint'(rate), sn, cs);
        t        = v;
        t.pos_x  = POS_W'(rotate_sat(longint'(v.pos_x), cs, longint'(v.pos_z), -sn,
                                     POS_W));
        t.pos_z  = POS_W'(rotate_sat(longint'(v.pos_x), sn, longint'(v.pos_z), cs,
                                     POS_W));
        t.norm_x = NORM_W'(rotate_sat(longint'(v.norm_x), cs, longint'(v.norm_z), -sn,
                                      NORM_W));
        t.norm_z = NORM_W'(rotate_sat(longint'(v.norm_x), sn, longint'(v.norm_z), cs,
                                      NORM_W));
        return t;
    endfunction

    // mostly short gaps, some medium, a few long; none in a burst
    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // field value of width w: extremes, zero, small or any bit pattern
    function automatic longint pick_field(int w);
        longint top;
        top = (longint'(1) << (w - 1)) - 1;
        case ($urandom_range(0, 9))
            0:       return top;
            1:       return -top - 1;
            2:       return 0;
            3, 4:    return longint'($urandom_range(0, 4095)) - 2048;
            default: return longint'($urandom);
        endcase
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        v.pos_x  = POS_W'(pick_field(POS_W));
        v.pos_y  = POS_W'(pick_field(POS_W));
        v.pos_z  = POS_W'(pick_field(POS_W));
        v.norm_x = NORM_W'(pick_field(NORM_W));
        v.norm_y = NORM_W'(pick_field(NORM_W));
        v.norm_z = NORM_W'(pick_field(NORM_W));
        return v;
    endfunction

    task automatic push_vertex(longint px, longint py, longint pz,
                               longint nx, longint ny, longint nz);
        vertex_t v;
        v.pos_x  = POS_W'(px);
        v.pos_y  = POS_W'(py);
        v.pos_z  = POS_W'(pz);
        v.norm_x = NORM_W'(nx);
        v.norm_y = NORM_W'(ny);
        v.norm_z = NORM_W'(nz);
        vertices_waiting = {vertices_waiting, v};
    endtask

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        @(negedge clk);
        while (vertices_waiting.size() != 0 || s_axis_tvalid || twisted_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_twist_rate(logic signed [RATE_W-1:0] rate);
        @(posedge clk);
        cfg_data  <= rate;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        model_rate = rate;
        rate_writes++;
    endtask

    // input driver: offers queued vertices with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
                src_burst <= !src_burst;
            // transfer accepted: predict its twisted vertex
            if (s_axis_tvalid && s_axis_tready)
            begin
                twisted_due = {twisted_due,
                               twist_vertex(vertex_t'(s_axis_tdata), model_rate)};
                vertices_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (vertices_waiting.size() > 0)
                begin
                    s_axis_tdata  <= vertices_waiting.pop_front();
                    s_axis_tvalid <= 1'b1;
                    src_gap       <= pick_gap(src_burst);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output ready: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_wait     <= 0;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                sink_burst <= !sink_burst;
            if (choke_served != choke_requests)
            begin
                choke_served  <= choke_served + 1;
                sink_wait     <= CHOKE_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait     <= sink_wait - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_wait     <= pick_gap(sink_burst);
            end
        end
    end

    // output monitor: each transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (twisted_due.size() == 0)
            begin
                $error("output transfer with no vertex outstanding: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                due_vtx  = twisted_due.pop_front();
                seen_vtx = vertex_t'(m_axis_tdata);
                compare_field("out_pos_x", longint'(due_vtx.pos_x),
                              longint'(seen_vtx.pos_x));
                compare_field("out_pos_y", longint'(due_vtx.pos_y),
                              longint'(seen_vtx.pos_y));
                compare_field("out_pos_z", longint'(due_vtx.pos_z),
                              longint'(seen_vtx.pos_z));
                compare_field("out_norm_x", longint'(due_vtx.norm_x),
                              longint'(seen_vtx.norm_x));
                compare_field("out_norm_y", longint'(due_vtx.norm_y),
                              longint'(seen_vtx.norm_y));
                compare_field("out_norm_z", longint'(due_vtx.norm_z),
                              longint'(seen_vtx.norm_z));
                results_checked++;
            end
        end
    end

    // stimulus: reset, then one phase per twist rate setting
    initial
    begin
        int phase_rate [PHASES];
        int ph;
        int n;
        phase_rate = '{4096, 32767, -32768, 1, -1, 0, 0, 0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset rate of zero: field extremes
        @(negedge clk);
        push_vertex(0, 0, 0, 0, 0, 0);
        push_vertex(8388607, 8388607, 8388607, 32767, 32767, 32767);
        push_vertex(-8388608, -8388608, -8388608, -32768, -32768, -32768);
        push_vertex(8388607, -8388608, -8388608, 32767, 0, -32768);

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            if (ph < 6)
                write_twist_rate(RATE_W'(phase_rate[ph]));
            else
                write_twist_rate(RATE_W'($urandom_range(0, 65535)));
            @(negedge clk);
            if (ph == 0)
            begin
                // one radian per unit height: y sets the angle directly
                push_vertex(8388607, 25736, -8388608, 32767, 100, -32768);
                push_vertex(-8388608, 25736, 8388607, -32768, -100, 32767);
                push_vertex(8388607, 25736, 8388607, 32767, 0, 32767);
                push_vertex(1000000, 51472, -2000000, 16384, 5, -16384);
                push_vertex(1000000, -51472, -2000000, 16384, 5, -16384);
                // beyond +-pi/2: folded by pi
                push_vertex(3000000, 77208, 1234567, 23170, 7, 23170);
                push_vertex(3000000, -77208, 1234567, 23170, 7, 23170);
                push_vertex(-500000, 102944, 700000, -32768, 9, 32767);
                push_vertex(-500000, -102944, 700000, -32768, 9, 32767);
                // full turns and negative remainders
                push_vertex(2500000, 205887, -2500000, 12000, 1, -12000);
                push_vertex(2500000, -205887, -2500000, 12000, 1, -12000);
                push_vertex(8388607, 8388607, 8388607, 32767, -1, 32767);
                push_vertex(-8388608, -8388608, -8388608, -32768, 1, -32768);
                push_vertex(8388607, 1, 0, 32767, 0, 0);
                push_vertex(0, -1, 8388607, 0, 0, 32767);
            end
            // long output hold-off while the input keeps offering
            if (ph == 1)
                choke_requests <= choke_requests + 1;
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                vertices_waiting = {vertices_waiting, random_vertex()};
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (twisted_due.size() != 0)
        begin
            $error("%0d twisted vertices never came out", twisted_due.size());
            mismatches++;
        end
        $display("%0d of %0d vertices checked across %0d twist rate writes,",
                 results_checked, vertices_sent, rate_writes);
        $display("rates at zero, unit, both signed extremes and random, one long output stall");
        if (mismatches == 0)
            $display("vertex_twist_deformer verification clean");
        else
            $display("vertex_twist_deformer verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #6ms;
        $display("vertex_twist_deformer verification failed");
        $finish;
    end

endmodule
